// File: src/run_slice_line_rasterizer_assert.svh
// Assertion macros used by the line rasterizer checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RUN_SLICE_LINE_RASTERIZER_ASSERT_SVH
`define RUN_SLICE_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RSLR_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rasterizer check failed");

// Next-cycle implication, disabled in reset.
`define RSLR_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rasterizer check failed");

`endif

// File: src/rslr_pkg.sv
package rslr_pkg;

  // Fixed width of the coordinate fields on the ports
  localparam int FIELD_W = 12;

  // Default internal coordinate width
  localparam int COORD_BITS_DEF = 12;

  // Transaction function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] start_x;
    logic [FIELD_W-1:0] start_y;
    logic [FIELD_W-1:0] end_x;
    logic [FIELD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [FIELD_W-1:0] pixel_x;
    logic [FIELD_W-1:0] pixel_y;
    logic               last_pixel;
  } out_item_t;

endpackage

// File: src/rslr_div.sv
module rslr_div #(
  parameter int WIDTH = rslr_pkg::COORD_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] div_r, div_nxt;
  logic [WIDTH:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[WIDTH-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? WIDTH'(trial - {1'b0, div_r}) : trial[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: src/run_slice_line_rasterizer.sv
// Step transaction: one per cycle while idle and the output register can move; its pixel appears
// in the output register the next cycle. Axis-aligned load: the block stays idle. Sloped load: no new
// transaction until the restoring divider (one quotient bit per cycle) is done.
// Reset is synchronous, active low: clears state, active flag and output valid;
// segment and payload registers keep their contents.
module run_slice_line_rasterizer #(
  parameter int COORD_BITS = rslr_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rslr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rslr_pkg::out_item_t out_data
);

  localparam int CW = COORD_BITS;
  localparam int RW = COORD_BITS + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_r, state_nxt;
  logic active_r, active_nxt;
  logic out_valid_r, out_valid_nxt;
  rslr_pkg::out_item_t out_data_r, out_data_nxt;

  logic [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CW-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic          neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic          x_major_r, x_major_nxt;
  logic [RW-1:0] base_run_r, base_run_nxt;
  logic [RW-1:0] run_rem_r, run_rem_nxt;
  logic [RW-1:0] minor_r, minor_nxt;
  logic [RW-1:0] err_r, err_nxt;
  logic [RW-1:0] left_r, left_nxt;

  logic          accept, is_load, is_step;
  logic [CW-1:0] sx, sy, ex, ey;
  logic [RW-1:0] adx, ady, maj, mnr;
  logic          div_start, div_done;
  logic [RW-1:0] div_quo, div_rem;
  logic [RW:0]   err_sum;
  logic          last;
  logic [CW-1:0] step_x, step_y;

  // Take a transaction only when idle and the output register can move
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_load  = accept && (in_data.func == rslr_pkg::FUNC_LOAD);
  assign is_step  = accept && (in_data.func == rslr_pkg::FUNC_STEP);

  // Drop input bits above the coordinate width
  assign sx = CW'(in_data.start_x);
  assign sy = CW'(in_data.start_y);
  assign ex = CW'(in_data.end_x);
  assign ey = CW'(in_data.end_y);

  // Inclusive spans of a sloped segment
  assign adx = (sx > ex) ? RW'(sx - ex) + 1'b1 : RW'(ex - sx) + 1'b1;
  assign ady = (sy > ey) ? RW'(sy - ey) + 1'b1 : RW'(ey - sy) + 1'b1;
  assign maj = (adx >= ady) ? adx : ady;
  assign mnr = (adx >= ady) ? ady : adx;

  assign div_start = is_load && (sx != ex) && (sy != ey);

  rslr_div #(.WIDTH(RW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (maj),
    .divisor   (mnr),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Step arithmetic: next positions and remainder accumulation
  assign last    = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
  assign step_x  = neg_x_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
  assign step_y  = neg_y_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
  assign err_sum = {1'b0, err_r} + {1'b0, run_rem_r};

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    tgt_x_nxt     = tgt_x_r;
    tgt_y_nxt     = tgt_y_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    x_major_nxt   = x_major_r;
    base_run_nxt  = base_run_r;
    run_rem_nxt   = run_rem_r;
    minor_nxt     = minor_r;
    err_nxt       = err_r;
    left_nxt      = left_r;

    // Drain the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (is_load) begin
          active_nxt  = 1'b1;
          err_nxt     = '0;
          run_rem_nxt = '0;
          neg_x_nxt   = 1'b0;
          neg_y_nxt   = 1'b0;
          minor_nxt   = RW'(1);
          if (sx == ex) begin
            x_major_nxt  = 1'b0;
            cur_x_nxt    = sx;
            tgt_x_nxt    = sx;
            cur_y_nxt    = (sy < ey) ? sy : ey;
            tgt_y_nxt    = (sy < ey) ? ey : sy;
            base_run_nxt = (sy < ey) ? RW'(ey - sy) + 1'b1 : RW'(sy - ey) + 1'b1;
            left_nxt     = base_run_nxt;
          end else if (sy == ey) begin
            x_major_nxt  = 1'b1;
            cur_y_nxt    = sy;
            tgt_y_nxt    = sy;
            cur_x_nxt    = (sx < ex) ? sx : ex;
            tgt_x_nxt    = (sx < ex) ? ex : sx;
            base_run_nxt = (sx < ex) ? RW'(ex - sx) + 1'b1 : RW'(sx - ex) + 1'b1;
            left_nxt     = base_run_nxt;
          end else begin
            neg_x_nxt   = sx > ex;
            neg_y_nxt   = sy > ey;
            x_major_nxt = adx >= ady;
            cur_x_nxt   = sx;
            cur_y_nxt   = sy;
            tgt_x_nxt   = ex;
            tgt_y_nxt   = ey;
            minor_nxt   = mnr;
            state_nxt   = ST_DIV;
          end
        end else if (is_step) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (active_r) begin
            out_data_nxt.pixel_valid = 1'b1;
            out_data_nxt.pixel_x     = rslr_pkg::FIELD_W'(cur_x_r);
            out_data_nxt.pixel_y     = rslr_pkg::FIELD_W'(cur_y_r);
            out_data_nxt.last_pixel  = last;
            if (last) begin
              active_nxt = 1'b0;
            end else if (left_r > RW'(1)) begin
              // Stay in the run: advance the major axis only
              left_nxt = left_r - 1'b1;
              if (x_major_r) begin
                cur_x_nxt = step_x;
              end else begin
                cur_y_nxt = step_y;
              end
            end else begin
              // Run boundary: diagonal move, start the next run
              cur_x_nxt = step_x;
              cur_y_nxt = step_y;
              if (err_sum >= {1'b0, minor_r}) begin
                err_nxt  = RW'(err_sum - {1'b0, minor_r});
                left_nxt = base_run_r + 1'b1;
              end else begin
                err_nxt  = err_sum[RW-1:0];
                left_nxt = base_run_r;
              end
            end
          end
        end
      end
      ST_DIV: begin
        // Remainder is below the minor count, so the first run gets no extra pixel
        if (div_done) begin
          base_run_nxt = div_quo;
          run_rem_nxt  = div_rem;
          err_nxt      = div_rem;
          left_nxt     = div_quo;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    tgt_x_r    <= tgt_x_nxt;
    tgt_y_r    <= tgt_y_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    x_major_r  <= x_major_nxt;
    base_run_r <= base_run_nxt;
    run_rem_r  <= run_rem_nxt;
    minor_r    <= minor_nxt;
    err_r      <= err_nxt;
    left_r     <= left_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/rslr_checker.sv
`include "run_slice_line_rasterizer_assert.svh"

module rslr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rslr_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rslr_pkg::out_item_t out_data
);

  // Hold a stalled result
  `RSLR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Every step transaction leaves a result in the output register
  `RSLR_ASSERT_NXT(a_step_result,
    in_valid && in_ready && (in_data.func == rslr_pkg::FUNC_STEP), out_valid)

  // An idle step result carries all zero fields
  `RSLR_ASSERT_IMP(a_idle_zero, out_valid && !out_data.pixel_valid,
    !out_data.last_pixel && (out_data.pixel_x == '0) && (out_data.pixel_y == '0))

  // After the last pixel drains with no new input, the output register is empty
  `RSLR_ASSERT_NXT(a_last_ends,
    out_valid && out_ready && out_data.last_pixel && !in_valid,
    !out_valid)

endmodule

bind run_slice_line_rasterizer rslr_checker u_rslr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
